// ===== rtl/tpc_pkg.sv =====
// shared types and constants for the triangle plane clipper
`default_nettype none
package tpc_pkg;
    localparam int FRAC_BITS = 16;
    localparam int T_BITS = 30;
    localparam int D_W = 56;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [23:0] u;
        logic signed [23:0] v;
    } t_vtx;

    // one classified triangle handed from the front to the back
    typedef struct packed {
        t_vtx [2:0]      p;
        logic [2:0][D_W-1:0] dm;  // distance magnitudes
        logic [2:0]      pos;     // sign positive
        logic [1:0]      kind;
        logic [1:0]      sel;     // lone or zero vertex
    } t_tri;

    localparam logic [1:0] K_WHOLE = 2'd0;
    localparam logic [1:0] K_SPLIT3 = 2'd1;
    localparam logic [1:0] K_SPLIT2 = 2'd2;

    function automatic logic [1:0] nxt(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/tpc_front.sv =====
// vertex collection, plane distance and sign classification
`default_nettype none
module tpc_front import tpc_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  t_vtx  i_vtx,
    input  wire  [17:0] i_nx,
    input  wire  [17:0] i_ny,
    input  wire  [17:0] i_nz,
    input  wire  [31:0] i_off,
    output logic        o_valid,
    input  wire         i_ready,
    output t_tri        o_tri
);
    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_DIST = 3'd1;
    localparam logic [2:0] S_SUM = 3'd2;
    localparam logic [2:0] S_CLASS = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_cnt, r_di;
    t_vtx [2:0] r_p;
    logic signed [D_W-1:0] r_d [3];
    logic signed [50:0] r_mx, r_my, r_mz;
    t_tri r_tri;

    assign o_ready = (r_state == S_COLLECT);
    assign o_valid = (r_state == S_OUT);
    assign o_tri = r_tri;

    logic signed [D_W-1:0] w_sum;
    assign w_sum = D_W'(r_mx) + D_W'(r_my) + D_W'(r_mz)
                 - (D_W'($signed(i_off)) <<< FRAC_BITS);

    logic [2:0] w_pos, w_neg;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pos[k] = !r_d[k][D_W-1] && (r_d[k] != '0);
            w_neg[k] = r_d[k][D_W-1];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: if (i_valid && r_cnt == 2'd2) n_state = S_DIST;
            S_DIST:    n_state = S_SUM;
            S_SUM:     n_state = (r_di == 2'd2) ? S_CLASS : S_DIST;
            S_CLASS:   n_state = ((w_pos | w_neg) == 3'd0) ? S_COLLECT : S_OUT;
            S_OUT:     if (i_ready) n_state = S_COLLECT;
            default:   n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_cnt <= 2'd0;
            r_di <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_COLLECT && i_valid) begin
                r_p[r_cnt] <= i_vtx;
                r_cnt <= (r_cnt == 2'd2) ? 2'd0 : r_cnt + 2'd1;
                r_di <= 2'd0;
            end
            if (r_state == S_DIST) begin
                r_mx <= $signed(i_nx) * r_p[r_di].x;
                r_my <= $signed(i_ny) * r_p[r_di].y;
                r_mz <= $signed(i_nz) * r_p[r_di].z;
            end
            if (r_state == S_SUM) begin
                r_d[r_di] <= w_sum;
                r_di <= r_di + 2'd1;
            end
            if (r_state == S_CLASS) begin
                r_tri.p <= r_p;
                r_tri.pos <= w_pos;
                for (int k = 0; k < 3; k++)
                    r_tri.dm[k] <= w_neg[k] ? -r_d[k] : r_d[k];
                if (w_pos == 3'd0 || w_neg == 3'd0) begin
                    r_tri.kind <= K_WHOLE;
                    r_tri.sel <= 2'd0;
                end else if ((w_pos | w_neg) == 3'b111) begin
                    r_tri.kind <= K_SPLIT3;
                    if ($countones(w_pos) == 1)
                        r_tri.sel <= w_pos[0] ? 2'd0 : (w_pos[1] ? 2'd1 : 2'd2);
                    else
                        r_tri.sel <= w_neg[0] ? 2'd0 : (w_neg[1] ? 2'd1 : 2'd2);
                end else begin
                    r_tri.kind <= K_SPLIT2;
                    r_tri.sel <= !(w_pos[0] | w_neg[0]) ? 2'd0 :
                                 (!(w_pos[1] | w_neg[1]) ? 2'd1 : 2'd2);
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tpc_queue.sv =====
// two-entry triangle queue between front and back
`default_nettype none
module tpc_queue import tpc_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  t_tri  i_tri,
    output logic        o_valid,
    input  wire         i_ready,
    output t_tri        o_tri
);
    t_tri r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tri = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_tri;
                r_wp <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tpc_back.sv =====
// edge cuts by restoring division and emission of output vertices
`default_nettype none
module tpc_back import tpc_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  wire  t_tri   i_tri,
    output logic         o_valid,
    input  wire          i_ready,
    output t_vtx         o_vtx,
    output logic         o_side,
    output logic [1:0]   o_corner,
    output logic         o_last
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV = 3'd1;
    localparam logic [2:0] S_MUL = 3'd2;
    localparam logic [2:0] S_RND = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state;
    t_tri r_t;
    logic [3:0] r_nv, r_vi;
    logic [4:0] r_bit;
    logic r_cut;         // which cut is being computed
    logic [2:0] r_fi;
    logic [D_W:0] r_r, r_s;
    logic [T_BITS-1:0] r_q;
    logic [1:0] r_ei, r_ej;
    t_vtx r_c [2];
    logic signed [63:0] r_prod;
    logic signed [32:0] r_base;
    logic r_ov;
    t_vtx r_ovx;
    logic r_oside, r_olast;
    logic [1:0] r_ocor;

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_vtx = r_ovx;
    assign o_side = r_oside;
    assign o_corner = r_ocor;
    assign o_last = r_olast;

    logic [1:0] w_a, w_b;
    assign w_a = nxt(r_t.sel);
    assign w_b = nxt(w_a);

    function automatic logic signed [32:0] fld(input t_vtx v, input logic [2:0] f);
        logic signed [32:0] r;
        r = '0;
        case (f)
            3'd0: r = 33'(v.x);
            3'd1: r = 33'(v.y);
            3'd2: r = 33'(v.z);
            3'd3: r = 33'(v.u);
            default: r = 33'(v.v);
        endcase
        return r;
    endfunction

    // cut edges: split3 uses b->c then c->a, split2 uses a->b
    logic [1:0] w_i, w_j;
    always_comb begin
        if (r_t.kind == K_SPLIT2) begin
            w_i = w_a; w_j = w_b;
        end else if (!r_cut) begin
            w_i = w_b; w_j = r_t.sel;
        end else begin
            w_i = r_t.sel; w_j = w_a;
        end
    end

    // source of emitted vertex: 0..2 stored vertex, 3 cut0, 4 cut1
    logic [2:0] w_src;
    logic w_side;
    always_comb begin
        w_src = 3'd0;
        w_side = 1'b0;
        case (r_t.kind)
            K_WHOLE: begin
                w_src = {1'b0, r_vi[1:0]};
                w_side = (r_t.pos != 3'd0);
            end
            K_SPLIT3: begin
                w_side = (r_vi < 4'd6) ? r_t.pos[w_a] : r_t.pos[r_t.sel];
                case (r_vi)
                    4'd0, 4'd3: w_src = {1'b0, w_a};
                    4'd1: w_src = {1'b0, w_b};
                    4'd2, 4'd4, 4'd8: w_src = 3'd3;
                    4'd6: w_src = {1'b0, r_t.sel};
                    default: w_src = 3'd4;
                endcase
            end
            default: begin
                w_side = (r_vi < 4'd3) ? r_t.pos[w_a] : r_t.pos[w_b];
                case (r_vi)
                    4'd0, 4'd3: w_src = {1'b0, r_t.sel};
                    4'd1: w_src = {1'b0, w_a};
                    4'd5: w_src = {1'b0, w_b};
                    default: w_src = 3'd3;
                endcase
            end
        endcase
    end

    logic [D_W:0] w_r2;
    assign w_r2 = {r_r[D_W-1:0], 1'b0};
    logic signed [32:0] w_diff, w_res;
    assign w_diff = fld(r_t.p[w_j], r_fi) - fld(r_t.p[w_i], r_fi);
    assign w_res = r_base + 33'((r_prod + (64'sd1 <<< (T_BITS - 1))) >>> T_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready && r_state != S_EMIT) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && !r_ov) begin
                    r_t <= i_tri;
                    r_vi <= 4'd0;
                    r_cut <= 1'b0;
                    r_nv <= (i_tri.kind == K_WHOLE) ? 4'd3 :
                            (i_tri.kind == K_SPLIT3) ? 4'd9 : 4'd6;
                    r_state <= (i_tri.kind == K_WHOLE) ? S_EMIT : S_DIV;
                    r_bit <= 5'd0;
                    r_q <= '0;
                    r_ei <= 2'd0;
                    r_ej <= 2'd0;
                end
                S_DIV: begin
                    if (r_bit == 5'd0 && r_ei == 2'd0) begin
                        r_r <= {1'b0, r_t.dm[w_i]};
                        r_s <= {1'b0, r_t.dm[w_i]} + {1'b0, r_t.dm[w_j]};
                        r_ei <= 2'd1;
                    end else begin
                        if (w_r2 >= r_s) begin
                            r_r <= w_r2 - r_s;
                            r_q <= {r_q[T_BITS-2:0], 1'b1};
                        end else begin
                            r_r <= w_r2;
                            r_q <= {r_q[T_BITS-2:0], 1'b0};
                        end
                        if (r_bit == 5'(T_BITS - 1)) begin
                            r_state <= S_MUL;
                            r_fi <= 3'd0;
                        end
                        r_bit <= r_bit + 5'd1;
                    end
                end
                S_MUL: begin
                    r_prod <= 64'(w_diff) * $signed({1'b0, r_q});
                    r_base <= fld(r_t.p[w_i], r_fi);
                    r_state <= S_RND;
                end
                S_RND: begin
                    case (r_fi)
                        3'd0: r_c[r_cut].x <= w_res[31:0];
                        3'd1: r_c[r_cut].y <= w_res[31:0];
                        3'd2: r_c[r_cut].z <= w_res[31:0];
                        3'd3: r_c[r_cut].u <= w_res[23:0];
                        default: r_c[r_cut].v <= w_res[23:0];
                    endcase
                    if (r_fi == 3'd4) begin
                        if (r_t.kind == K_SPLIT3 && !r_cut) begin
                            r_cut <= 1'b1;
                            r_bit <= 5'd0;
                            r_ei <= 2'd0;
                            r_q <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_fi <= r_fi + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: if (!r_ov || i_ready) begin
                    r_ov <= 1'b1;
                    r_ovx <= (w_src == 3'd3) ? r_c[0] :
                             (w_src == 3'd4) ? r_c[1] : r_t.p[w_src[1:0]];
                    r_oside <= w_side;
                    r_ocor <= r_ej;
                    r_olast <= (r_vi == r_nv - 4'd1);
                    r_ej <= (r_ej == 2'd2) ? 2'd0 : r_ej + 2'd1;
                    r_vi <= r_vi + 4'd1;
                    if (r_vi == r_nv - 4'd1) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/triangle_plane_clip.sv =====
// triangle plane clipper top level
// vertices enter on i_valid/o_ready, three make one triangle; the first two
// are stored, the third starts classification against the plane
// n . p - offset programmed over the apb port (0 nx, 4 ny, 8 nz, c offset)
// output vertices leave on o_valid/i_ready, corner 0..2 per output triangle,
// side tag, and last on the final vertex of the input triangle
// front: collects one vertex per cycle, then computes each distance in a
// multiply stage and a sum stage, then classifies and hands off; back: a load
// state, per edge cut a restoring division to a 30-bit quotient and a
// multiply and round per vertex field, then one vertex per cycle while i_ready
// a two-entry queue lets the front classify the next triangle while the
// back still cuts or waits on a stalled receiver
// a stalled receiver holds the output register and back-pressures the queue
// synchronous reset returns registers to nz = 1.0, others zero, and empties
// all stages; stored vertices are not cleared
`default_nettype none
module triangle_plane_clip import tpc_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [31:0] i_x_coord,
    input  wire  [31:0] i_y_coord,
    input  wire  [31:0] i_z_coord,
    input  wire  [23:0] i_tex_u,
    input  wire  [23:0] i_tex_v,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic [23:0] o_out_u,
    output logic [23:0] o_out_v,
    output logic        o_side_positive,
    output logic [1:0]  o_corner,
    output logic        o_last
);
    localparam logic [1:0] R_NX = 2'd0;
    localparam logic [1:0] R_NY = 2'd1;
    localparam logic [1:0] R_NZ = 2'd2;
    localparam logic [1:0] R_OFF = 2'd3;

    logic [17:0] r_nx, r_ny, r_nz;
    logic [31:0] r_off;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0;
            r_ny <= '0;
            r_nz <= 18'd65536;
            r_off <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                R_NX:  r_nx <= pwdata[17:0];
                R_NY:  r_ny <= pwdata[17:0];
                R_NZ:  r_nz <= pwdata[17:0];
                R_OFF: r_off <= pwdata;
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[3:2])
            R_NX:  prdata = {{14{r_nx[17]}}, r_nx};
            R_NY:  prdata = {{14{r_ny[17]}}, r_ny};
            R_NZ:  prdata = {{14{r_nz[17]}}, r_nz};
            default: prdata = r_off;
        endcase
    end

    t_vtx w_in, w_out;
    assign w_in = '{x: i_x_coord, y: i_y_coord, z: i_z_coord, u: i_tex_u, v: i_tex_v};

    logic f_valid, f_ready, q_valid, q_ready;
    t_tri f_tri, q_tri;

    tpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_vtx(w_in),
        .i_nx(r_nx), .i_ny(r_ny), .i_nz(r_nz), .i_off(r_off),
        .o_valid(f_valid), .i_ready(f_ready), .o_tri(f_tri)
    );
    tpc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_tri(f_tri),
        .o_valid(q_valid), .i_ready(q_ready), .o_tri(q_tri)
    );
    tpc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_tri(q_tri),
        .o_valid(o_valid), .i_ready(i_ready), .o_vtx(w_out),
        .o_side(o_side_positive), .o_corner(o_corner), .o_last(o_last)
    );
    assign o_out_x = w_out.x;
    assign o_out_y = w_out.y;
    assign o_out_z = w_out.z;
    assign o_out_u = w_out.u;
    assign o_out_v = w_out.v;
endmodule
`default_nettype wire
